[rtl/hsob_pkg.sv]
// Shared types, constants and tables for the harmonic oscillator bank.
// No dependencies.
package hsob_pkg;

    localparam int NUM_HARMONICS_DEF = 8;
    localparam int CORDIC_ITER_DEF   = 24;

    localparam logic signed [23:0] Q22_ONE   = 24'sh400000;
    localparam logic signed [23:0] S24_MAX   = 24'sh7FFFFF;
    localparam logic signed [23:0] S24_MIN   = -24'sh800000;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [23:0] q22_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667266;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic q22_t sat24(input logic signed [33:0] v);
        q22_t r;
        if (v > 34'(S24_MAX)) begin
            r = S24_MAX;
        end else if (v < 34'(S24_MIN)) begin
            r = S24_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

[rtl/hsob_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on hsob_pkg.
module hsob_cordic #(
    parameter int ITER = hsob_pkg::CORDIC_ITER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       phase,
    output logic              done,
    output hsob_pkg::q22_t    sin_out,
    output hsob_pkg::q22_t    cos_out
);
    localparam int CNT_W = $clog2(ITER);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        iter_reg, iter_next;
    logic signed [33:0]      x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                    neg_reg, neg_next;
    hsob_pkg::q22_t          sin_reg, sin_next, cos_reg, cos_next;

    logic signed [33:0] z0, xs, ys, at, xn, yn, xr, yr;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        sin_next  = sin_reg;
        cos_next  = cos_reg;
        z0 = {{2{phase[31]}}, phase};
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = $signed({2'b00, hsob_pkg::atan_turn(5'(iter_reg))});
        if (z_reg >= 0) begin
            xn = x_reg - ys;
            yn = y_reg + xs;
        end else begin
            xn = x_reg + ys;
            yn = y_reg - xs;
        end
        xr = (xn + 34'sd128) >>> 8;
        yr = (yn + 34'sd128) >>> 8;
        if (neg_reg) begin
            xr = -xr;
            yr = -yr;
        end
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = hsob_pkg::CORDIC_X0;
            y_next    = '0;
            neg_next  = 1'b0;
            z_next    = z0;
            if (z0 > 34'sd1073741824) begin
                z_next   = z0 - 34'sd2147483648;
                neg_next = 1'b1;
            end else if (z0 < -34'sd1073741824) begin
                z_next   = z0 + 34'sd2147483648;
                neg_next = 1'b1;
            end
        end else if (busy_reg) begin
            x_next = xn;
            y_next = yn;
            z_next = (z_reg >= 0) ? z_reg - at : z_reg + at;
            iter_next = iter_reg + 1'b1;
            if (iter_reg == CNT_W'(ITER - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cos_next  = hsob_pkg::sat24(xr);
                sin_next  = hsob_pkg::sat24(yr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        iter_reg <= iter_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        neg_reg  <= neg_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
    end

    assign done    = done_reg;
    assign sin_out = sin_reg;
    assign cos_out = cos_reg;
endmodule

[rtl/hsob_rotate.sv]
// Bit-serial coupled-form rotation of one oscillator, one coefficient bit per cycle.
// Depends on hsob_pkg.
module hsob_rotate (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  hsob_pkg::q22_t s_in,
    input  hsob_pkg::q22_t c_in,
    input  hsob_pkg::q22_t ss_in,
    input  hsob_pkg::q22_t sc_in,
    output logic           done,
    output hsob_pkg::q22_t s_out,
    output hsob_pkg::q22_t c_out
);
    logic               busy_reg, busy_next, done_reg, done_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [49:0] ps_reg, ps_next, pc_reg, pc_next;
    logic signed [49:0] as_reg, as_next, ac_reg, ac_next;
    logic [23:0]        mss_reg, mss_next, msc_reg, msc_next;
    hsob_pkg::q22_t     s_reg, s_next, c_reg, c_next;

    logic               last;
    logic signed [49:0] tps, tpc, fin_s, fin_c;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        ps_next   = ps_reg;
        pc_next   = pc_reg;
        as_next   = as_reg;
        ac_next   = ac_reg;
        mss_next  = mss_reg;
        msc_next  = msc_reg;
        s_next    = s_reg;
        c_next    = c_reg;
        last = (cnt_reg == 5'd23);
        tps  = last ? -ps_reg : ps_reg;
        tpc  = last ? -pc_reg : pc_reg;
        as_next = as_reg + (msc_reg[0] ? tps : 50'sd0) + (mss_reg[0] ? tpc : 50'sd0);
        ac_next = ac_reg + (msc_reg[0] ? tpc : 50'sd0) - (mss_reg[0] ? tps : 50'sd0);
        fin_s = (as_next + 50'sd2097152) >>> 22;
        fin_c = (ac_next + 50'sd2097152) >>> 22;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            ps_next   = 50'(s_in);
            pc_next   = 50'(c_in);
            as_next   = '0;
            ac_next   = '0;
            mss_next  = ss_in;
            msc_next  = sc_in;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            ps_next  = ps_reg <<< 1;
            pc_next  = pc_reg <<< 1;
            mss_next = mss_reg >> 1;
            msc_next = msc_reg >> 1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                s_next    = hsob_pkg::sat24(fin_s[33:0]);
                c_next    = hsob_pkg::sat24(fin_c[33:0]);
            end
        end else begin
            as_next = as_reg;
            ac_next = ac_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        ps_reg  <= ps_next;
        pc_reg  <= pc_next;
        as_reg  <= as_next;
        ac_reg  <= ac_next;
        mss_reg <= mss_next;
        msc_reg <= msc_next;
        s_reg   <= s_next;
        c_reg   <= c_next;
    end

    assign done  = done_reg;
    assign s_out = s_reg;
    assign c_out = c_reg;
endmodule

[rtl/hsob_divider.sv]
// Restoring divider, one quotient bit per cycle, sixteen-bit quotient.
// No dependencies on other files.
module hsob_divider #(
    parameter int NUM_W = 46,
    parameter int DEN_W = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [15:0]      quot
);
    localparam int CMP_W = ((NUM_W > DEN_W + 15) ? NUM_W : DEN_W + 15) + 1;

    logic             busy_reg, busy_next, done_reg, done_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [CMP_W-1:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [15:0]      q_reg, q_next;
    logic             ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        ge = (rem_reg >= dsh_reg);
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = CMP_W'(num);
            dsh_next  = CMP_W'(den) << 15;
            q_next    = '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[14:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

[rtl/harmonic_sine_oscillator_bank_core.sv]
// Harmonic sine oscillator bank: note load via CORDIC, tick via serial rotation and mix.
// Note item: its time is bound by the CORDIC.
// Tick item: the result comes from bit-serial multipliers.
// One item at a time; the output register lets a new item in while a sample waits.
// Reset (aresetn low, synchronous) sets every oscillator to zero frequency: output silent.
// Depends on hsob_pkg, hsob_cordic, hsob_rotate, hsob_divider.
module harmonic_sine_oscillator_bank_core #(
    parameter int NUM_HARMONICS     = hsob_pkg::NUM_HARMONICS_DEF,
    parameter int CORDIC_ITERATIONS = hsob_pkg::CORDIC_ITER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [31:0]        s_fundamental_step,
    input  logic [15:0]        s_harmonic_spread,
    input  logic [15:0]        s_decay,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample
);
    localparam int IDX_W   = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
    localparam int SCALE_W = 16 + $clog2(NUM_HARMONICS);
    localparam int ACC_W   = 40 + $clog2(NUM_HARMONICS);
    localparam int DEN_W   = SCALE_W + 10;
    localparam int NUM_W   = ACC_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_NMUL = 8'b0000_0010,
        ST_CORD = 8'b0000_0100,
        ST_ROT  = 8'b0000_1000,
        ST_WGT  = 8'b0001_0000,
        ST_PREP = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    hsob_pkg::q22_t osc_sin_reg [NUM_HARMONICS];
    hsob_pkg::q22_t osc_cos_reg [NUM_HARMONICS];
    hsob_pkg::q22_t stp_sin_reg [NUM_HARMONICS];
    hsob_pkg::q22_t stp_cos_reg [NUM_HARMONICS];

    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [31:0]             fsh_reg, fsh_next, fh_reg, fh_next, ph_reg, ph_next;
    logic [5:0]              hsh_reg, hsh_next;
    logic [15:0]             amp_reg, amp_next, ash_reg, ash_next;
    logic [31:0]             dsh_reg, dsh_next;
    logic [30:0]             prod_reg, prod_next;
    logic signed [39:0]      wsh_reg, wsh_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic                    neg_reg, neg_next;
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [15:0]      m_sample_reg, m_sample_next;
    logic                    cord_go_reg, cord_go_next, rot_go_reg, rot_go_next;
    logic                    div_go_reg, div_go_next;

    logic                    wr_step, wr_osc;
    logic [16:0]             spread_sum;
    logic [5:0]              h_val;
    logic [15:0]             d_clamp;
    logic [ACC_W-1:0]        mag;
    logic [DEN_W-1:0]        den_val;
    logic [30:0]             amp_round;
    logic [15:0]             qmag;

    logic                    cord_done, rot_done, div_done;
    hsob_pkg::q22_t          cord_sin, cord_cos, rot_s, rot_c;
    logic [15:0]             quot;

    hsob_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cord_go_reg), .phase(ph_reg),
        .done(cord_done), .sin_out(cord_sin), .cos_out(cord_cos)
    );

    hsob_rotate u_rotate (
        .aclk(aclk), .aresetn(aresetn), .start(rot_go_reg),
        .s_in(osc_sin_reg[idx_reg]), .c_in(osc_cos_reg[idx_reg]),
        .ss_in(stp_sin_reg[idx_reg]), .sc_in(stp_cos_reg[idx_reg]),
        .done(rot_done), .s_out(rot_s), .c_out(rot_c)
    );

    hsob_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_divider (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg), .num(num_reg),
        .den(den_reg), .done(div_done), .quot(quot)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        fsh_next      = fsh_reg;
        fh_next       = fh_reg;
        ph_next       = ph_reg;
        hsh_next      = hsh_reg;
        amp_next      = amp_reg;
        ash_next      = ash_reg;
        dsh_next      = dsh_reg;
        prod_next     = prod_reg;
        wsh_next      = wsh_reg;
        acc_next      = acc_reg;
        scale_next    = scale_reg;
        neg_next      = neg_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        m_valid_next  = m_valid_reg;
        m_sample_next = m_sample_reg;
        cord_go_next  = 1'b0;
        rot_go_next   = 1'b0;
        div_go_next   = 1'b0;
        wr_step       = 1'b0;
        wr_osc        = 1'b0;

        spread_sum = {1'b0, s_harmonic_spread} + 17'd2047;
        h_val      = (spread_sum[16:11] == 6'd0) ? 6'd1 : spread_sum[16:11];
        d_clamp    = (s_decay > 16'd32768) ? 16'd32768 : s_decay;
        mag        = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        den_val    = (DEN_W'(scale_reg) << 9) + (DEN_W'(scale_reg) << 7);
        amp_round  = prod_reg + 31'd16384;
        qmag       = (quot > 16'd32768) ? 16'd32768 : quot;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                cnt_next = '0;
                if (s_valid) begin
                    if (!s_kind) begin
                        fsh_next   = s_fundamental_step;
                        ph_next    = s_fundamental_step;
                        hsh_next   = h_val;
                        fh_next    = '0;
                        state_next = ST_NMUL;
                    end else begin
                        dsh_next    = {16'd0, d_clamp};
                        amp_next    = 16'd32768;
                        acc_next    = '0;
                        scale_next  = '0;
                        rot_go_next = 1'b1;
                        state_next  = ST_ROT;
                    end
                end
            end
            ST_NMUL: begin
                if (hsh_reg[0]) begin
                    fh_next = fh_reg + fsh_reg;
                end
                fsh_next = fsh_reg << 1;
                hsh_next = hsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd5) begin
                    cord_go_next = 1'b1;
                    state_next   = ST_CORD;
                end
            end
            ST_CORD: begin
                if (cord_done) begin
                    wr_step = 1'b1;
                    if (idx_reg == IDX_W'(NUM_HARMONICS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next     = idx_reg + 1'b1;
                        ph_next      = ph_reg + fh_reg;
                        cord_go_next = 1'b1;
                    end
                end
            end
            ST_ROT: begin
                if (rot_done) begin
                    wr_osc     = 1'b1;
                    wsh_next   = 40'(rot_s);
                    ash_next   = amp_reg;
                    prod_next  = '0;
                    scale_next = scale_reg + SCALE_W'(amp_reg);
                    cnt_next   = '0;
                    state_next = ST_WGT;
                end
            end
            ST_WGT: begin
                if (ash_reg[0]) begin
                    acc_next  = acc_reg + ACC_W'(wsh_reg);
                    prod_next = prod_reg + dsh_reg[30:0];
                end
                wsh_next = wsh_reg <<< 1;
                dsh_next = dsh_reg << 1;
                ash_next = ash_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15) begin
                    dsh_next = dsh_reg >> 15;
                    if (idx_reg == IDX_W'(NUM_HARMONICS - 1)) begin
                        state_next = ST_PREP;
                    end else begin
                        idx_next    = idx_reg + 1'b1;
                        rot_go_next = 1'b1;
                        state_next  = ST_ROT;
                    end
                end
            end
            ST_PREP: begin
                neg_next    = acc_reg[ACC_W-1];
                den_next    = den_val;
                num_next    = NUM_W'(mag) + NUM_W'(den_val >> 1);
                div_go_next = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_sample_next = -$signed(17'(qmag)) >= -17'sd32768 ?
                                        16'(-$signed(17'(qmag))) : 16'sh8000;
                    end else begin
                        m_sample_next = (qmag > 16'd32767) ? 16'sh7FFF : $signed(qmag);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_WGT && cnt_reg == 4'd15) begin
            amp_next = 16'((ash_reg[0] ? (amp_round + dsh_reg[30:0]) : amp_round) >> 15);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cord_go_reg <= 1'b0;
            rot_go_reg  <= 1'b0;
            div_go_reg  <= 1'b0;
            for (int i = 0; i < NUM_HARMONICS; i++) begin
                osc_sin_reg[i] <= '0;
                osc_cos_reg[i] <= hsob_pkg::Q22_ONE;
                stp_sin_reg[i] <= '0;
                stp_cos_reg[i] <= hsob_pkg::Q22_ONE;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cord_go_reg <= cord_go_next;
            rot_go_reg  <= rot_go_next;
            div_go_reg  <= div_go_next;
            if (wr_step) begin
                stp_sin_reg[idx_reg] <= cord_sin;
                stp_cos_reg[idx_reg] <= cord_cos;
                osc_sin_reg[idx_reg] <= '0;
                osc_cos_reg[idx_reg] <= hsob_pkg::Q22_ONE;
            end
            if (wr_osc) begin
                osc_sin_reg[idx_reg] <= rot_s;
                osc_cos_reg[idx_reg] <= rot_c;
            end
        end
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        fsh_reg      <= fsh_next;
        fh_reg       <= fh_next;
        ph_reg       <= ph_next;
        hsh_reg      <= hsh_next;
        amp_reg      <= amp_next;
        ash_reg      <= ash_next;
        dsh_reg      <= dsh_next;
        prod_reg     <= prod_next;
        wsh_reg      <= wsh_next;
        acc_reg      <= acc_next;
        scale_reg    <= scale_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        m_sample_reg <= m_sample_next;
    end

    a_cord_done_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cord_done |-> state_reg == ST_CORD)
        else $error("CORDIC finished outside a note load");

    a_rot_done_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        rot_done |-> state_reg == ST_ROT)
        else $error("rotation finished outside a tick");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished tick");
endmodule

[tb/sv/harmonic_sine_oscillator_bank_core_test.sv]
`timescale 1ns / 1ps
// Self-checking test of the harmonic oscillator bank core: directed and random
// note/tick items with random idling on both sides, samples checked in order.
// Depends on hsob_pkg and harmonic_sine_oscillator_bank_core.
module harmonic_sine_oscillator_bank_core_test;

    localparam int NH    = hsob_pkg::NUM_HARMONICS_DEF;
    localparam int ITERS = hsob_pkg::CORDIC_ITER_DEF;
    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    class sample_scoreboard;
        longint osc_s[NH];
        longint osc_c[NH];
        longint coef_s[NH];
        longint coef_c[NH];
        logic signed [15:0] pending_samples[$];
        int errors;
        int checked;
        int notes;

        function new();
            for (int i = 0; i < NH; i++) begin
                osc_s[i] = 0;
                osc_c[i] = 64'sd4194304;
                coef_s[i] = 0;
                coef_c[i] = 64'sd4194304;
            end
            errors = 0;
            checked = 0;
            notes = 0;
        endfunction

        function longint clamp24(longint v);
            if (v > 64'sd8388607) return 64'sd8388607;
            if (v < -64'sd8388608) return -64'sd8388608;
            return v;
        endfunction

        function void rotator_coefs(logic [31:0] ph, output longint sv, output longint cv);
            longint z, x, y, xs, ys;
            bit flip;
            z = (ph < 32'h8000_0000) ? longint'(ph) : longint'(ph) - 64'sd4294967296;
            flip = 0;
            x = 64'sd652032874;
            y = 0;
            if (z > 64'sd1073741824) begin
                z -= 64'sd2147483648;
                flip = 1;
            end else if (z < -64'sd1073741824) begin
                z += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < ITERS && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(hsob_pkg::atan_turn(5'(i)));
                end else begin
                    x += ys; y -= xs; z += longint'(hsob_pkg::atan_turn(5'(i)));
                end
            end
            x = (x + 128) >>> 8;
            y = (y + 128) >>> 8;
            if (flip) begin
                x = -x; y = -y;
            end
            cv = clamp24(x);
            sv = clamp24(y);
        endfunction

        function void note_input(logic kind, logic [31:0] fund, logic [15:0] spread,
                                 logic [15:0] decay);
            longint unsigned h, mult, acc_mag, div;
            longint ns, nc, amp, wsum, acc, d, q;
            logic [31:0] ph;
            if (kind == KIND_NOTE) begin
                notes++;
                h = (longint'(spread) + 2047) >> 11;
                if (h < 1) h = 1;
                for (int i = 0; i < NH; i++) begin
                    mult = longint'(i) * h + 1;
                    ph = 32'(longint'(fund) * mult);
                    rotator_coefs(ph, coef_s[i], coef_c[i]);
                    osc_s[i] = 0;
                    osc_c[i] = 64'sd4194304;
                end
            end else begin
                d = longint'(decay);
                if (d > 32768) d = 32768;
                amp = 32768;
                wsum = 0;
                acc = 0;
                for (int i = 0; i < NH; i++) begin
                    ns = osc_s[i] * coef_c[i] + osc_c[i] * coef_s[i];
                    nc = osc_c[i] * coef_c[i] - osc_s[i] * coef_s[i];
                    osc_s[i] = clamp24((ns + 2097152) >>> 22);
                    osc_c[i] = clamp24((nc + 2097152) >>> 22);
                    acc += amp * osc_s[i];
                    wsum += amp;
                    amp = (amp * d + 16384) >>> 15;
                end
                div = wsum * 640;
                acc_mag = (acc < 0) ? -acc : acc;
                acc_mag = (acc_mag + div / 2) / div;
                if (acc_mag > 32768) acc_mag = 32768;
                q = (acc < 0) ? -longint'(acc_mag) : longint'(acc_mag);
                if (q > 32767) q = 32767;
                pending_samples.push_back(16'(q));
            end
        endfunction

        function void check_sample(logic signed [15:0] got, realtime t);
            logic signed [15:0] want;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample %0d", t, got);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            checked++;
            if (got !== want) begin
                $display("%0t: sample mismatch, expected %0d actual %0d", t, want, got);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_kind;
    logic [31:0] s_fundamental_step;
    logic [15:0] s_harmonic_spread;
    logic [15:0] s_decay;
    logic m_valid;
    logic m_ready;
    logic signed [15:0] m_sample;
    bit quiet;

    sample_scoreboard sb;

    harmonic_sine_oscillator_bank_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_fundamental_step(s_fundamental_step), .s_harmonic_spread(s_harmonic_spread),
        .s_decay(s_decay),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample(m_sample)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        m_ready = 0;
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_sample(m_sample, $realtime);
        end
    end

    task automatic send_item(logic kind, logic [31:0] fund, logic [15:0] spread,
                             logic [15:0] decay);
        if (!quiet && $urandom_range(99) < 26) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= kind;
        s_fundamental_step <= fund;
        s_harmonic_spread <= spread;
        s_decay <= decay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(kind, fund, spread, decay);
    endtask

    task automatic random_item();
        logic [15:0] d;
        d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        if ($urandom_range(99) < 15) begin
            send_item(KIND_NOTE, $urandom, 16'($urandom), 16'($urandom));
        end else begin
            send_item(KIND_TICK, $urandom, 16'($urandom), d);
        end
    endtask

    initial begin
        int waited;
        sb = new();
        quiet = 0;
        aresetn = 0;
        s_valid = 0;
        s_kind = KIND_NOTE;
        s_fundamental_step = 0;
        s_harmonic_spread = 0;
        s_decay = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed items, starting with ticks that are silent after reset
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_item(KIND_NOTE, 32'd0, 16'd0, 16'hFFFF);
        send_item(KIND_TICK, 0, 0, 16'd16384);
        send_item(KIND_NOTE, 32'h0100_0000, 16'd0, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_TICK, 0, 0, 16'hFFFF);
        send_item(KIND_TICK, 0, 0, 16'd0);
        send_item(KIND_NOTE, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32769);
        send_item(KIND_TICK, 0, 0, 16'd32767);
        send_item(KIND_NOTE, 32'h4000_0000, 16'd1, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_NOTE, 32'h4000_0001, 16'd2048, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_NOTE, 32'h8000_0000, 16'd2049, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_NOTE, 32'hC000_0000, 16'd32768, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd24000);
        send_item(KIND_NOTE, 32'hBFFF_FFFF, 16'd4096, 16'd0);
        send_item(KIND_TICK, 0, 0, 16'd32768);
        send_item(KIND_TICK, 0, 0, 16'd32768);

        for (int n = 0; n < 1030; n++) begin
            quiet = (n >= 400 && n < 560);
            random_item();
        end
        s_valid <= 0;

        waited = 0;
        while (sb.pending_samples.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (500) @(posedge aclk);
        $display("Covered %0d note loads and %0d checked samples, random idling on both sides.",
                 sb.notes, sb.checked);
        if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
            $display("harmonic_sine_oscillator_bank_core regression: pass");
        end else begin
            $display("%0d mismatches, %0d samples never seen", sb.errors,
                     sb.pending_samples.size());
            $display("harmonic_sine_oscillator_bank_core regression: fail");
        end
        $finish;
    end

    initial begin
        #(64'd12 * 64'd4_000_000);
        $display("harmonic_sine_oscillator_bank_core regression: fail");
        $finish;
    end
endmodule

[harmonic_sine_oscillator_bank_core.f]
rtl/hsob_pkg.sv
rtl/hsob_cordic.sv
rtl/hsob_rotate.sv
rtl/hsob_divider.sv
rtl/harmonic_sine_oscillator_bank_core.sv
tb/sv/harmonic_sine_oscillator_bank_core_test.sv
